// ===== design/thermal_fan_and_trip_controller_core_macros.svh =====
// Assertion macros for the thermal fan and trip controller.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef THERMAL_FAN_AND_TRIP_CONTROLLER_CORE_MACROS_SVH
`define THERMAL_FAN_AND_TRIP_CONTROLLER_CORE_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define TFTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// An antecedent that must be followed by its consequent in the same cycle.
`define TFTC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// An antecedent that must be followed by its consequent in the next cycle.
`define TFTC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/tftc_pkg.sv =====
// Types and constants of the thermal fan and trip controller.
// No dependencies; used by the interfaces and the core.
package tftc_pkg;

  typedef logic signed [12:0] temp_t;
  typedef logic [9:0]         duty_t;
  typedef logic [1:0]         run_state_t;
  typedef logic [1:0]         cfg_index_t;
  typedef logic [12:0]        cfg_data_t;
  typedef logic [15:0]        millivolt_t;
  typedef logic [11:0]        megahertz_t;
  typedef logic [6:0]         percent_t;

  // Reported run states.
  localparam run_state_t RUN_MINING   = 2'd0;
  localparam run_state_t RUN_PAUSED   = 2'd1;
  localparam run_state_t RUN_SHUTDOWN = 2'd2;

  // Register indexes on the configuration channel.
  localparam cfg_index_t CFG_AUTO_FAN     = 2'd0;
  localparam cfg_index_t CFG_MANUAL_FAN   = 2'd1;
  localparam cfg_index_t CFG_ASIC_TRIP    = 2'd2;
  localparam cfg_index_t CFG_REG_TRIP     = 2'd3;

  // Fan duties in tenths of a percent.
  localparam duty_t FAN_PAUSED = 10'd300;
  localparam duty_t FAN_FULL   = 10'd1000;
  localparam duty_t FAN_MIN    = 10'd350;

  // Temperatures in 1/16 degree C.
  localparam temp_t CHIP_RAMP_LO = 13'sd720;
  localparam temp_t CHIP_RAMP_HI = 13'sd1200;
  localparam temp_t REG_RAMP_LO  = 13'sd960;
  localparam temp_t REG_RAMP_HI  = 13'sd1360;
  localparam temp_t NO_CHIP_TEMP = 13'sd800;

  // Trip qualifiers.
  localparam megahertz_t TRIP_MIN_MHZ = 12'd50;
  localparam millivolt_t TRIP_MIN_MV  = 16'd1000;

  localparam percent_t   MANUAL_MAX_PERCENT = 7'd100;

  // Register reset values.
  localparam percent_t RST_MANUAL_FAN = 7'd100;
  localparam temp_t    RST_ASIC_TRIP  = 13'sd1200;
  localparam temp_t    RST_REG_TRIP   = 13'sd1680;

  // Reciprocal of three, scaled by 2^17, exact for dividends below 2^11.
  localparam logic [15:0] RECIP3_Q17 = 16'd43691;

endpackage

// ===== design/tftc_if.sv =====
// Handshake channels of the thermal fan and trip controller: poll ticks,
// results and configuration writes. Depends on tftc_pkg.
interface tftc_in_if;
  import tftc_pkg::*;

  logic       valid;
  logic       ready;
  temp_t      chip_temp_a;
  temp_t      chip_temp_b;
  temp_t      regulator_temp;
  millivolt_t input_voltage_mv;
  megahertz_t core_frequency_mhz;
  logic       pause_request;
  logic       resume_ok;

  modport source (output valid, chip_temp_a, chip_temp_b, regulator_temp, input_voltage_mv,
                  core_frequency_mhz, pause_request, resume_ok, input ready);
  modport sink   (input valid, chip_temp_a, chip_temp_b, regulator_temp, input_voltage_mv,
                  core_frequency_mhz, pause_request, resume_ok, output ready);
endinterface

interface tftc_out_if;
  import tftc_pkg::*;

  logic       valid;
  logic       ready;
  duty_t      fan_duty;
  run_state_t run_state;
  logic       resume_failed;
  temp_t      chip_temp_average;

  modport source (output valid, fan_duty, run_state, resume_failed, chip_temp_average,
                  input ready);
  modport sink   (input valid, fan_duty, run_state, resume_failed, chip_temp_average,
                  output ready);
endinterface

interface tftc_cfg_if;
  import tftc_pkg::*;

  logic       valid;
  logic       ready;
  cfg_index_t index;
  cfg_data_t  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/thermal_fan_and_trip_controller_core.sv =====
// Thermal fan and overheat trip controller: takes one poll tick per cycle and
// returns one result per tick in the next cycle, from a result register. A new
// tick is taken whenever the result register is empty or its contents are being
// transferred, so the sustained rate is one tick per cycle unless stalled; the
// path from the input channel to the result register is set by the two fan
// ramps (a constant scaling and a multiply by a reciprocal of three). Configuration
// writes are always taken and should be made only while no tick is in flight.
// Once an overheat trip has latched, every later result reports shutdown at full
// fan until reset. Depends on tftc_pkg, tftc_if and the macros header.
`include "thermal_fan_and_trip_controller_core_macros.svh"

module thermal_fan_and_trip_controller_core (
  input  logic clk_i,
  input  logic rst_ni,
  tftc_in_if.sink    in_i,
  tftc_out_if.source out_o,
  tftc_cfg_if.sink   cfg_i
);
  import tftc_pkg::*;

  // Configuration registers.
  logic     auto_fan_q;
  percent_t manual_fan_q;
  temp_t    asic_trip_q;
  temp_t    reg_trip_q;

  // Run state.
  logic paused_q, paused_d;
  logic trip_q, trip_d;

  // Result register.
  logic       out_valid_q;
  duty_t      fan_q, fan_d;
  run_state_t state_q, state_d;
  logic       fail_q, fail_d;
  temp_t      avg_q, avg_d;

  logic in_xfer;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_xfer     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auto_fan_q   <= 1'b1;
      manual_fan_q <= RST_MANUAL_FAN;
      asic_trip_q  <= RST_ASIC_TRIP;
      reg_trip_q   <= RST_REG_TRIP;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_AUTO_FAN:   auto_fan_q   <= cfg_i.data[0];
        CFG_MANUAL_FAN: manual_fan_q <= cfg_i.data[6:0];
        CFG_ASIC_TRIP:  asic_trip_q  <= temp_t'(cfg_i.data);
        CFG_REG_TRIP:   reg_trip_q   <= temp_t'(cfg_i.data);
        default: ;
      endcase
    end
  end

  // Chip validity, average, hottest chip and trip conditions.
  logic             chip_a_ok, chip_b_ok;
  logic signed [13:0] temp_sum;
  temp_t            hot_temp;
  logic             trip_hit, trip_armed;

  always_comb begin
    chip_a_ok = in_i.chip_temp_a > 13'sd0;
    chip_b_ok = in_i.chip_temp_b > 13'sd0;
    temp_sum  = 14'(in_i.chip_temp_a) + 14'(in_i.chip_temp_b);
    // Adding the sign bit before the shift rounds the halving toward zero.
    avg_d     = temp_t'((temp_sum + 14'(temp_sum[13])) >>> 1);
    if (chip_a_ok && chip_b_ok) begin
      hot_temp = (in_i.chip_temp_a > in_i.chip_temp_b) ? in_i.chip_temp_a : in_i.chip_temp_b;
    end else if (chip_a_ok) begin
      hot_temp = in_i.chip_temp_a;
    end else if (chip_b_ok) begin
      hot_temp = in_i.chip_temp_b;
    end else begin
      hot_temp = NO_CHIP_TEMP;
    end
    trip_hit   = (chip_a_ok && in_i.chip_temp_a > asic_trip_q) ||
                 (chip_b_ok && in_i.chip_temp_b > asic_trip_q) ||
                 (in_i.regulator_temp > reg_trip_q);
    trip_armed = (in_i.core_frequency_mhz > TRIP_MIN_MHZ) ||
                 (in_i.input_voltage_mv > TRIP_MIN_MV);
  end

  // Chip ramp: 650 tenths over 480 steps, that is d * 65 / 48.
  temp_t        chip_off;
  logic [8:0]   chip_d;
  logic [14:0]  chip_x65;
  logic [26:0]  chip_prod;
  duty_t        chip_fan;

  always_comb begin
    chip_off  = hot_temp - CHIP_RAMP_LO;
    chip_d    = chip_off[8:0];
    chip_x65  = {chip_d, 6'b0} + 15'(chip_d);
    chip_prod = 27'(chip_x65[14:4]) * 27'(RECIP3_Q17);
    if (hot_temp < CHIP_RAMP_LO) begin
      chip_fan = FAN_MIN;
    end else if (hot_temp >= CHIP_RAMP_HI) begin
      chip_fan = FAN_FULL;
    end else begin
      chip_fan = FAN_MIN + chip_prod[26:17];
    end
  end

  // Regulator ramp: 650 tenths over 400 steps, that is d * 13 / 8.
  temp_t        reg_off;
  logic [8:0]   reg_dlt;
  logic [12:0]  reg_x13;
  duty_t        reg_fan;

  always_comb begin
    reg_off = in_i.regulator_temp - REG_RAMP_LO;
    reg_dlt = reg_off[8:0];
    reg_x13 = {reg_dlt, 3'b0} + {1'b0, reg_dlt, 2'b0} + 13'(reg_dlt);
    if (in_i.regulator_temp < REG_RAMP_LO) begin
      reg_fan = FAN_MIN;
    end else if (in_i.regulator_temp >= REG_RAMP_HI) begin
      reg_fan = FAN_FULL;
    end else begin
      reg_fan = FAN_MIN + reg_x13[12:3];
    end
  end

  percent_t manual_sat;
  duty_t    manual_fan;
  duty_t    run_fan;

  always_comb begin
    manual_sat = (manual_fan_q > MANUAL_MAX_PERCENT) ? MANUAL_MAX_PERCENT : manual_fan_q;
    manual_fan = {manual_sat, 3'b0} + {2'b0, manual_sat, 1'b0};
    if (auto_fan_q) begin
      run_fan = (reg_fan > chip_fan) ? reg_fan : chip_fan;
    end else begin
      run_fan = manual_fan;
    end
  end

  // Tick decision.
  always_comb begin
    paused_d = paused_q;
    trip_d   = trip_q;
    fail_d   = 1'b0;
    if (trip_q) begin
      fan_d   = FAN_FULL;
      state_d = RUN_SHUTDOWN;
    end else begin
      if (in_i.pause_request && !paused_q) begin
        paused_d = 1'b1;
      end else if (!in_i.pause_request && paused_q) begin
        if (in_i.resume_ok) begin
          paused_d = 1'b0;
        end else begin
          fail_d = 1'b1;
        end
      end
      if (paused_d) begin
        fan_d   = FAN_PAUSED;
        state_d = RUN_PAUSED;
      end else if (trip_hit && trip_armed) begin
        trip_d  = 1'b1;
        fan_d   = FAN_FULL;
        state_d = RUN_SHUTDOWN;
      end else begin
        fan_d   = run_fan;
        state_d = RUN_MINING;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      paused_q    <= 1'b0;
      trip_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      paused_q    <= paused_d;
      trip_q      <= trip_d;
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // The average is reported only on a running tick or on the tick that trips.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      fan_q   <= fan_d;
      state_q <= state_d;
      fail_q  <= fail_d;
      avg_q   <= (trip_q || paused_d) ? 13'sd0 : avg_d;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.fan_duty          = fan_q;
  assign out_o.run_state         = state_q;
  assign out_o.resume_failed     = fail_q;
  assign out_o.chip_temp_average = avg_q;

  `TFTC_ASSERT_NXT(a_trip_sticks, trip_q, trip_q, "overheat trip released before reset")
  `TFTC_ASSERT(a_trip_not_paused, !(trip_q && paused_q), "tripped and paused at once")
  `TFTC_ASSERT_IMP(a_shutdown_full_fan, out_valid_q && state_q == RUN_SHUTDOWN,
                   fan_q == FAN_FULL, "shutdown result without full fan")
  `TFTC_ASSERT_IMP(a_paused_result, out_valid_q && state_q == RUN_PAUSED,
                   fan_q == FAN_PAUSED && avg_q == 13'sd0, "paused result malformed")
  `TFTC_ASSERT_IMP(a_fail_only_paused, out_valid_q && fail_q,
                   state_q == RUN_PAUSED && paused_q, "resume failure outside pause")

endmodule
